FILE: hw/rtl/radial_gradient_shape_fill_macros.svh
// Assertion macros used by the gradient painter top level.
// Depends on nothing; included by the top level, the one file that carries assertions.
`ifndef RADIAL_GRADIENT_SHAPE_FILL_MACROS_SVH
`define RADIAL_GRADIENT_SHAPE_FILL_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RGSF_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define RGSF_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define RGSF_ASSERT_IMP(lbl, c, r, a, b)
`define RGSF_ASSERT_NXT(lbl, c, r, a, b)
`endif
`endif

FILE: hw/rtl/rgsf_pkg.sv
// Shared constants, types and register codes of the gradient painter.
// Depends on nothing; used by the interfaces, front end, cell and top level.
`default_nettype none
package rgsf_pkg;
  localparam int IMAGE_ROWS = 480;
  localparam int IMAGE_COLS = 640;
  localparam int ROW_W = 9;
  localparam int COL_W = 10;
  localparam int GRAY_W = 8;
  localparam int SPAN_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int EXT_W = 12;
  localparam int M2_W = 19;
  localparam int D2_W = 22;
  localparam int TGT_W = 38;
  localparam int STEPS = 8;
  localparam int POS_W = 3;
  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'hFF;
  localparam logic [15:0] GRAY_SQ = 16'd65025;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE     = 3'd0,
    REG_TOP       = 3'd1,
    REG_LEFT      = 3'd2,
    REG_SPAN_ROWS = 3'd3,
    REG_SPAN_COLS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              shape_is_circle;
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  left_col;
    logic [SPAN_W-1:0] span_rows;
    logic [SPAN_W-1:0] span_cols;
  } cfg_t;

  // One pipeline slot travelling down the row of search cells.
  typedef struct packed {
    logic              valid;
    logic              covered;
    logic              m2_zero;
    logic              tgt_zero;
    logic [GRAY_W-1:0] background;
    logic [M2_W-1:0]   m2;
    logic [TGT_W-1:0]  target;
    logic [TGT_W-1:0]  acc_sq;
    logic [TGT_W-1:0]  acc_lin;
    logic [GRAY_W-1:0] k;
  } cell_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rgsf_if.sv
// Channel interfaces of the gradient painter: pixel in, result out, config.
// Depends on rgsf_pkg.
`default_nettype none
interface rgsf_pix_if;
  logic                          valid;
  logic                          ready;
  logic [rgsf_pkg::ROW_W-1:0]    pixel_row;
  logic [rgsf_pkg::COL_W-1:0]    pixel_col;
  logic [rgsf_pkg::GRAY_W-1:0]   background;
  modport source (output valid, pixel_row, pixel_col, background, input ready);
  modport sink (input valid, pixel_row, pixel_col, background, output ready);
endinterface

interface rgsf_res_if;
  logic                          valid;
  logic                          ready;
  logic [rgsf_pkg::GRAY_W-1:0]   gray_out;
  logic                          covered;
  modport source (output valid, gray_out, covered, input ready);
  modport sink (input valid, gray_out, covered, output ready);
endinterface

interface rgsf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rgsf_pkg::CFG_IDX_W-1:0]  index;
  logic [rgsf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rgsf_front.sv
// Two-stage front end: coverage test, squared distances and search target.
// Depends on rgsf_pkg.
`default_nettype none
module rgsf_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [rgsf_pkg::ROW_W-1:0]  pixel_row,
  input  wire logic [rgsf_pkg::COL_W-1:0]  pixel_col,
  input  wire logic [rgsf_pkg::GRAY_W-1:0] background,
  input  wire rgsf_pkg::cfg_t              cfg,
  output rgsf_pkg::cell_t                  out_c
);
  localparam int EW = rgsf_pkg::EXT_W;

  logic [rgsf_pkg::SPAN_W-2:0] hr, hc;
  logic [rgsf_pkg::SPAN_W-1:0] w;
  logic [EW-1:0] row_x, col_x, cen_r, cen_c, end_r, end_c;
  logic signed [EW-1:0] dr, dc;
  logic signed [2*EW-1:0] dr_p, dc_p;
  logic inbox;

  // Stage one registers.
  logic                        v1, inbox1, circ1;
  logic [rgsf_pkg::D2_W-1:0]   dr2, dc2;
  logic [rgsf_pkg::M2_W-1:0]   m2_1;
  logic [17:0]                 hr2_1;
  logic [rgsf_pkg::GRAY_W-1:0] bg1;

  logic [rgsf_pkg::D2_W-1:0]   d2;
  rgsf_pkg::cell_t             nxt;

  always_comb begin
    hr    = cfg.span_rows[rgsf_pkg::SPAN_W-1:1];
    hc    = cfg.shape_is_circle ? hr : cfg.span_cols[rgsf_pkg::SPAN_W-1:1];
    w     = cfg.shape_is_circle ? cfg.span_rows : cfg.span_cols;
    row_x = EW'(pixel_row);
    col_x = EW'(pixel_col);
    cen_r = EW'(cfg.top_row) + EW'(hr);
    cen_c = EW'(cfg.left_col) + EW'(hc);
    end_r = EW'(cfg.top_row) + EW'(cfg.span_rows);
    end_c = EW'(cfg.left_col) + EW'(w);
    dr    = $signed(row_x) - $signed(cen_r);
    dc    = $signed(col_x) - $signed(cen_c);
    dr_p  = dr * dr;
    dc_p  = dc * dc;
    inbox = (row_x < EW'(rgsf_pkg::IMAGE_ROWS)) && (col_x < EW'(rgsf_pkg::IMAGE_COLS))
         && (row_x >= EW'(cfg.top_row)) && (row_x < end_r)
         && (col_x >= EW'(cfg.left_col)) && (col_x < end_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      inbox1 <= inbox;
      circ1  <= cfg.shape_is_circle;
      dr2    <= dr_p[rgsf_pkg::D2_W-1:0];
      dc2    <= dc_p[rgsf_pkg::D2_W-1:0];
      hr2_1  <= 18'(hr) * 18'(hr);
      m2_1   <= rgsf_pkg::M2_W'(18'(hr) * 18'(hr)) + rgsf_pkg::M2_W'(18'(hc) * 18'(hc));
      bg1    <= background;
    end
  end

  always_comb begin
    d2             = dr2 + dc2;
    nxt            = '0;
    nxt.valid      = v1;
    nxt.covered    = inbox1 && (!circ1 || (d2 <= rgsf_pkg::D2_W'(hr2_1)));
    nxt.m2_zero    = (m2_1 == '0);
    nxt.tgt_zero   = (d2 == '0);
    nxt.background = bg1;
    nxt.m2         = m2_1;
    nxt.target     = rgsf_pkg::TGT_W'(d2) * rgsf_pkg::TGT_W'(rgsf_pkg::GRAY_SQ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_c.valid <= 1'b0;
    end else if (en) begin
      out_c <= nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rgsf_cell.sv
// One search cell: decides one bit of the largest k with k*k*m2 below target.
// Depends on rgsf_pkg.
`default_nettype none
module rgsf_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic [rgsf_pkg::POS_W-1:0] bit_pos,
  input  wire rgsf_pkg::cell_t            in_c,
  output rgsf_pkg::cell_t                 out_c
);
  logic [rgsf_pkg::TGT_W-1:0] m2w, trial;
  logic [rgsf_pkg::POS_W:0]   sh1;
  rgsf_pkg::cell_t            nxt;

  // (k + b)^2 m2 = k^2 m2 + 2 b k m2 + b^2 m2, with k m2 kept as a running sum.
  always_comb begin
    m2w   = rgsf_pkg::TGT_W'(in_c.m2);
    sh1   = {1'b0, bit_pos} + 1'b1;
    trial = in_c.acc_sq + (in_c.acc_lin << sh1) + (m2w << {bit_pos, 1'b0});
    nxt   = in_c;
    if (trial < in_c.target) begin
      nxt.acc_sq  = trial;
      nxt.acc_lin = in_c.acc_lin + (m2w << bit_pos);
      nxt.k       = in_c.k | (rgsf_pkg::GRAY_W'(1) << bit_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_c.valid <= 1'b0;
    end else if (en) begin
      out_c <= nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/radial_gradient_shape_fill.sv
// Top level of the radial gradient shape painter: config registers, pipeline, output.
// Depends on rgsf_pkg, rgsf_if, rgsf_front, rgsf_cell and the assertion macros.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------
//  pix     | in  | pixel_row, pixel_col, background
//  res     | out | gray_out, covered
//  cfg     | in  | index, data (register write, always ready)
//
// One pixel beat is taken every cycle while res does not stall; each beat passes through
// two front stages, eight search cells and one output register on its way to res.
// There are eight cells, one per bit of the gradient step k.
// Reset is synchronous and active high; it empties the pipeline and loads defaults.
// A stall on res freezes the whole pipeline and drops pix.ready in the same cycle.
`default_nettype none
`include "radial_gradient_shape_fill_macros.svh"
module radial_gradient_shape_fill (
  input wire logic clk,
  input wire logic rst,
  rgsf_cfg_if.sink cfg,
  rgsf_pix_if.sink pix,
  rgsf_res_if.source res
);
  rgsf_pkg::cfg_t  regs;
  rgsf_pkg::cell_t chain [rgsf_pkg::STEPS+1];
  rgsf_pkg::cell_t last;
  logic            en;
  logic [rgsf_pkg::GRAY_W-1:0] k_fin, gray_next;

  // Configuration writes are always accepted; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.shape_is_circle <= 1'b0;
      regs.top_row         <= '0;
      regs.left_col        <= '0;
      regs.span_rows       <= rgsf_pkg::SPAN_W'(1);
      regs.span_cols       <= rgsf_pkg::SPAN_W'(1);
    end else if (cfg.valid) begin
      unique case (rgsf_pkg::cfg_reg_t'(cfg.index))
        rgsf_pkg::REG_SHAPE:     regs.shape_is_circle <= cfg.data[0];
        rgsf_pkg::REG_TOP:       regs.top_row   <= cfg.data[rgsf_pkg::ROW_W-1:0];
        rgsf_pkg::REG_LEFT:      regs.left_col  <= cfg.data[rgsf_pkg::COL_W-1:0];
        rgsf_pkg::REG_SPAN_ROWS: regs.span_rows <= cfg.data;
        rgsf_pkg::REG_SPAN_COLS: regs.span_cols <= cfg.data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances whenever the output register is free or draining.
  assign en        = !res.valid || res.ready;
  assign pix.ready = en;

  rgsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (pix.valid),
    .pixel_row  (pix.pixel_row),
    .pixel_col  (pix.pixel_col),
    .background (pix.background),
    .cfg        (regs),
    .out_c      (chain[0])
  );

  // Cell i settles bit (7 - i) of k, most significant first.
  for (genvar i = 0; i < rgsf_pkg::STEPS; i++) begin : g_cell
    rgsf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bit_pos (rgsf_pkg::POS_W'(rgsf_pkg::STEPS - 1 - i)),
      .in_c    (chain[i]),
      .out_c   (chain[i+1])
    );
  end

  assign last = chain[rgsf_pkg::STEPS];

  // The cells find the largest k with k*k*m2 below the target; the ceiling is one
  // more, capped at full scale. A zero target or a zero corner distance are caught
  // here since the search alone cannot see them.
  always_comb begin
    k_fin = (last.k == rgsf_pkg::GRAY_MAX) ? rgsf_pkg::GRAY_MAX : last.k + 1'b1;
    if (!last.covered) begin
      gray_next = last.background;
    end else if (last.m2_zero || last.tgt_zero) begin
      gray_next = rgsf_pkg::GRAY_MAX;
    end else begin
      gray_next = rgsf_pkg::GRAY_MAX - k_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= last.valid;
    end
    if (en) begin
      res.gray_out <= gray_next;
      res.covered  <= last.covered;
    end
  end

  `RGSF_ASSERT_IMP(a_stall_blocks_input, clk, rst, res.valid && !res.ready, !pix.ready)
  `RGSF_ASSERT_IMP(a_empty_out_ready, clk, rst, !res.valid, pix.ready)
  `RGSF_ASSERT_NXT(a_res_held, clk, rst, res.valid && !res.ready, res.valid)
endmodule
`default_nettype wire

FILE: dv/rgsf_tb_if.sv
// Testbench constants of the gradient painter: the pipeline depth used to pad drains.
// Depends on nothing; the channel interfaces come from the RTL interface file.
package rgsf_tb_pkg;
  localparam int LATENCY = 11;
endpackage

FILE: dv/tb.sv
// Testbench of radial_gradient_shape_fill: random and directed pixel beats with
// an in-bench gradient predictor. Depends on rgsf_pkg, rgsf_if and rgsf_tb_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [rgsf_pkg::ROW_W-1:0]  row;
    logic [rgsf_pkg::COL_W-1:0]  col;
    logic [rgsf_pkg::GRAY_W-1:0] bg;
  } pixel_t;

  typedef struct packed {
    logic [rgsf_pkg::GRAY_W-1:0] gray;
    logic                        cov;
  } paint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rgsf_cfg_if cfg();
  rgsf_pix_if pix();
  rgsf_res_if res();

  radial_gradient_shape_fill u_dut (
    .clk(clk), .rst(rst), .cfg(cfg), .pix(pix), .res(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the shape registers, updated when a config beat is taken.
  rgsf_pkg::cfg_t shape;
  pixel_t pixel_queue[$];
  paint_t paint_queue[$];
  int unsigned wait_in, wait_out;
  bit failed = 1'b0;
  longint unsigned cycle_count = 0;

  // Smallest k in 0..255 with k*k*m2 >= 65025*d2, by binary search.
  function automatic logic [7:0] gradient_step(longint unsigned d2, longint unsigned m2);
    longint unsigned lo, hi, mid, goal;
    lo = 0;
    hi = 255;
    goal = 64'd65025 * d2;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (mid * mid * m2 >= goal) hi = mid;
      else lo = mid + 1;
    end
    return 8'(lo);
  endfunction

  // Paints one pixel against the shadowed shape.
  function automatic paint_t paint_pixel(pixel_t p);
    longint r, c, top, left, h, w, hr, hc, dr, dc;
    longint unsigned d2, m2;
    paint_t o;
    r = p.row;
    c = p.col;
    top = shape.top_row;
    left = shape.left_col;
    h = shape.span_rows;
    w = shape.shape_is_circle ? h : longint'(shape.span_cols);
    hr = h / 2;
    hc = w / 2;
    dr = r - (top + hr);
    dc = c - (left + hc);
    d2 = dr * dr + dc * dc;
    m2 = shape.shape_is_circle ? 2 * hr * hr : hr * hr + hc * hc;
    o.cov = (r < rgsf_pkg::IMAGE_ROWS) && (c < rgsf_pkg::IMAGE_COLS) && (r >= top) &&
            (r < top + h) && (c >= left) && (c < left + w);
    if (shape.shape_is_circle && d2 > hr * hr) o.cov = 1'b0;
    if (!o.cov) o.gray = p.bg;
    else if (m2 == 0) o.gray = rgsf_pkg::GRAY_MAX;
    else o.gray = rgsf_pkg::GRAY_MAX - gradient_step(d2, m2);
    return o;
  endfunction

  // Pixel driver: one beat at a time from the queue, with a random gap after each.
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      pix.pixel_row <= '0;
      pix.pixel_col <= '0;
      pix.background <= '0;
      wait_in <= 0;
    end else if (pix.valid && !pix.ready) begin
      // Hold the beat until the block takes it.
    end else begin
      if (pix.valid && pix.ready) begin
        paint_queue.push_back(paint_pixel({pix.pixel_row, pix.pixel_col, pix.background}));
      end
      if (wait_in != 0) begin
        wait_in <= wait_in - 1;
        pix.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        pixel_t p;
        p = pixel_queue.pop_front();
        pix.valid <= 1'b1;
        pix.pixel_row <= p.row;
        pix.pixel_col <= p.col;
        pix.background <= p.bg;
        wait_in <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Result monitor: random ready stalls, each beat checked against the oldest paint.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      wait_out <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (paint_queue.size() == 0) begin
          $display("%0t: result beat with nothing expected: gray %0d covered %0b",
                   $time, res.gray_out, res.covered);
          failed = 1'b1;
        end else begin
          paint_t e;
          e = paint_queue.pop_front();
          if (e.gray !== res.gray_out) begin
            $display("%0t: gray_out expected %0d actual %0d", $time, e.gray, res.gray_out);
            failed = 1'b1;
          end
          if (e.cov !== res.covered) begin
            $display("%0t: covered expected %0b actual %0b", $time, e.cov, res.covered);
            failed = 1'b1;
          end
        end
      end
      if (wait_out != 0) begin
        wait_out <= wait_out - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        wait_out <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("** radial_gradient_shape_fill: FAILED **");
      $finish;
    end
  end

  // Writes one shape register through the config channel.
  task automatic write_reg(rgsf_pkg::cfg_reg_t idx, logic [rgsf_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      rgsf_pkg::REG_SHAPE:     shape.shape_is_circle = value[0];
      rgsf_pkg::REG_TOP:       shape.top_row = value[rgsf_pkg::ROW_W-1:0];
      rgsf_pkg::REG_LEFT:      shape.left_col = value;
      rgsf_pkg::REG_SPAN_ROWS: shape.span_rows = value;
      rgsf_pkg::REG_SPAN_COLS: shape.span_cols = value;
      default: ;
    endcase
    cfg.valid <= 1'b0;
  endtask

  task automatic set_shape(bit circ, int t, int l, int hr, int wc);
    write_reg(rgsf_pkg::REG_SHAPE, rgsf_pkg::CFG_DATA_W'(circ));
    write_reg(rgsf_pkg::REG_TOP, rgsf_pkg::CFG_DATA_W'(t));
    write_reg(rgsf_pkg::REG_LEFT, rgsf_pkg::CFG_DATA_W'(l));
    write_reg(rgsf_pkg::REG_SPAN_ROWS, rgsf_pkg::CFG_DATA_W'(hr));
    write_reg(rgsf_pkg::REG_SPAN_COLS, rgsf_pkg::CFG_DATA_W'(wc));
  endtask

  task automatic queue_pixel(int r, int c, int b);
    pixel_t p;
    p.row = rgsf_pkg::ROW_W'(r);
    p.col = rgsf_pkg::COL_W'(c);
    p.bg = rgsf_pkg::GRAY_W'(b);
    pixel_queue.push_back(p);
  endtask

  // Waits until every queued beat was taken and every result arrived, then pads
  // the drain with idle clocks, so that a register write sees an idle block.
  task automatic drain();
    while (pixel_queue.size() != 0 || pix.valid || paint_queue.size() != 0)
      @(posedge clk);
    repeat (rgsf_tb_pkg::LATENCY + 4) @(posedge clk);
  endtask

  // Mostly pixels in and around the shape box, some anywhere in the field range.
  task automatic random_phase(int count);
    int r, c;
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) begin
        r = int'(shape.top_row) + $urandom_range(0, shape.span_rows + 3) - 2;
        c = int'(shape.left_col) + $urandom_range(0, shape.span_rows + shape.span_cols + 3) - 2;
        r = r < 0 ? 0 : (r > 511 ? 511 : r);
        c = c < 0 ? 0 : (c > 1023 ? 1023 : c);
      end else begin
        r = $urandom_range(0, 511);
        c = $urandom_range(0, 1023);
      end
      queue_pixel(r, c, $urandom_range(0, 255));
    end
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = rgsf_pkg::REG_SHAPE;
    cfg.data = '0;
    shape = '{shape_is_circle: 1'b0, top_row: '0, left_col: '0, span_rows: 10'd1,
              span_cols: 10'd1};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset shape: a single pixel at the origin with zero corner distance.
    queue_pixel(0, 0, 8'h12);
    queue_pixel(0, 1, 8'hff);
    queue_pixel(1, 0, 8'h00);
    drain();

    // Rectangle with its centre, two opposite corners and outside neighbours.
    set_shape(0, 100, 200, 41, 60);
    queue_pixel(120, 230, 7);
    queue_pixel(100, 200, 7);
    queue_pixel(140, 259, 7);
    queue_pixel(141, 259, 7);
    queue_pixel(140, 260, 7);
    queue_pixel(99, 200, 7);
    drain();

    // Circle reaching past the image edge, and pixels beyond the image.
    set_shape(1, 470, 630, 31, 5);
    queue_pixel(479, 639, 8'haa);
    queue_pixel(485, 645, 8'haa);
    queue_pixel(511, 1023, 8'h55);
    queue_pixel(470, 630, 8'h55);
    drain();

    // Zero span paints nothing; largest registers.
    set_shape(0, 10, 10, 0, 0);
    queue_pixel(10, 10, 3);
    drain();
    set_shape(1, 511, 1023, 1023, 1023);
    queue_pixel(479, 639, 4);
    drain();

    random_phase(270);
    drain();
    set_shape(1, 0, 0, 640, 1);
    random_phase(270);
    drain();
    set_shape(0, 0, 0, 480, 640);
    random_phase(270);
    drain();
    repeat (4) begin
      set_shape($urandom_range(0, 1), $urandom_range(0, 480), $urandom_range(0, 640),
                $urandom_range(1, 120), $urandom_range(1, 120));
      random_phase(260);
      drain();
    end
    set_shape(1, 200, 300, 2, 640);
    random_phase(100);
    drain();

    if (!failed) begin
      $display("** radial_gradient_shape_fill: PASSED **");
    end else begin
      $display("** radial_gradient_shape_fill: FAILED **");
    end
    $finish;
  end
endmodule

FILE: radial_gradient_shape_fill.f
+incdir+hw/rtl
hw/rtl/rgsf_pkg.sv
hw/rtl/rgsf_if.sv
hw/rtl/rgsf_front.sv
hw/rtl/rgsf_cell.sv
hw/rtl/radial_gradient_shape_fill.sv
dv/rgsf_tb_if.sv
dv/tb.sv
